@@ rtl/mtss_pkg.sv @@
// shared constants, register map and sine table for the multi-tone sine generator
`default_nettype none

package mtss_pkg;

    localparam int MAX_TONES       = 4;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_DEPTH      = 1 << SINE_TABLE_BITS;

    // register map, 64-bit registers at byte address 8*index
    localparam int NUM_TONE_REGS = 4;
    localparam int REG_IDX_W     = 3;
    localparam int PADDR_W       = 6;
    localparam int PDATA_W       = 64;

    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_TONES = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TONE_WORD_0  = 3'd1;

    localparam int ACTIVE_W    = 3;
    localparam int TONE_WORD_W = 63;
    localparam int INC_W       = 32;
    localparam int PHASE_W     = 16;
    localparam int AMP_W       = 15;
    localparam int SINE_W      = 16;
    localparam int PROD_W      = AMP_W + 1 + SINE_W;
    localparam int TERM_W      = PROD_W - 15;
    localparam int SUM_W       = TERM_W + $clog2(MAX_TONES + 1);

    localparam int TIME_W     = 32;
    localparam int SAMPLE_W   = 18;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 24;

    localparam logic signed [SUM_W-1:0] SAMPLE_MAX = SUM_W'(131071);
    localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -SUM_W'(131072);

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] COEF1   = 64'd1686629713;
    localparam logic [63:0] COEF3   = 64'd693598668;
    localparam logic [63:0] COEF5   = 64'd85569306;
    localparam logic [63:0] COEF7   = 64'd5026995;
    localparam logic [63:0] COEF9   = 64'd172272;

    typedef logic signed [SINE_W-1:0] sine_t;
    typedef logic [SINE_DEPTH-1:0][SINE_W-1:0] sine_table_t;

    // sin(pi/2 * u), u and result in q30
    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] u);
        logic [63:0] u2;
        logic [63:0] p;
        u2 = (u * u) >> 30;
        p  = COEF9;
        p  = COEF7 - ((p * u2) >> 30);
        p  = COEF5 - ((p * u2) >> 30);
        p  = COEF3 - ((p * u2) >> 30);
        p  = COEF1 - ((p * u2) >> 30);
        return (p * u) >> 30;
    endfunction

    function automatic logic [SINE_W-1:0] sine_entry(input int i);
        int          qbits;
        int          qsize;
        int          quad;
        int          r;
        int          pos;
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] m;
        qbits = SINE_TABLE_BITS - 2;
        qsize = 1 << qbits;
        quad  = (i >> qbits) & 3;
        r     = i & (qsize - 1);
        pos   = ((quad & 1) != 0) ? (qsize - r) : r;
        u     = 64'(pos) << (30 - qbits);
        s     = quarter_sine_q30(u);
        m     = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (m > 64'd32767)
        begin
            m = 64'd32767;
        end
        return ((quad & 2) != 0) ? -m[SINE_W-1:0] : m[SINE_W-1:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            tbl[i] = sine_entry(i);
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

@@ rtl/multi_tone_sine_sum.sv @@
// a request passes the stage 1, 2, 3 and output registers before it shows on m_tvalid
// throughput: one request per cycle; the four-stage pipeline (phase multiply,
// sine lookup, amplitude multiply, sum and saturate) stalls only on m_tready
// reset: rst_n clears the stage valid bits and all configuration registers
// (active_tones = 0, tone words = 0), so output is an error sample until set up
`default_nettype none

module multi_tone_sine_sum
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // apb configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mtss_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [mtss_pkg::PDATA_W-1:0]        pwdata,
    output logic      [mtss_pkg::PDATA_W-1:0]        prdata,
    output logic                                     pready,
    // sample index stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [mtss_pkg::IN_TDATA_W-1:0]     s_tdata,  // [31:0] sample_time
    // sample stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [mtss_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [17:0] sample_value, [23:18] 0
    output logic      [0:0]                          m_tuser   // [0] setup_error
);
    import mtss_pkg::*;

    logic [ACTIVE_W-1:0]    active_tones_reg;
    logic [TONE_WORD_W-1:0] tone_word_reg [MAX_TONES];
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   cfg_write;

    logic [MAX_TONES-1:0]   tone_on;
    logic                   setup_err;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic en1, en2, en3, en_out;

    logic [INC_W-1:0]         phase_mul_reg [MAX_TONES];
    sine_t                    sine_reg      [MAX_TONES];
    logic signed [PROD_W-1:0] prod_reg      [MAX_TONES];
    logic signed [SUM_W-1:0]  sum;
    logic [SAMPLE_W-1:0]      sample_next;
    logic [SAMPLE_W-1:0]      sample_reg;
    logic                     err_reg;

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_tones_reg <= '0;
            for (int k = 0; k < MAX_TONES; k++)
            begin
                tone_word_reg[k] <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (reg_idx == REG_ACTIVE_TONES)
            begin
                active_tones_reg <= pwdata[ACTIVE_W-1:0];
            end
            for (int k = 0; k < MAX_TONES; k++)
            begin
                if (k < NUM_TONE_REGS && reg_idx == REG_IDX_W'(int'(REG_TONE_WORD_0) + k))
                begin
                    tone_word_reg[k] <= pwdata[TONE_WORD_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_ACTIVE_TONES)
        begin
            prdata = PDATA_W'(active_tones_reg);
        end
        for (int k = 0; k < MAX_TONES; k++)
        begin
            if (k < NUM_TONE_REGS && reg_idx == REG_IDX_W'(int'(REG_TONE_WORD_0) + k))
            begin
                prdata = PDATA_W'(tone_word_reg[k]);
            end
        end
    end

    // tones beyond MAX_TONES simply do not exist, which caps the count
    always_comb
    begin
        setup_err = (active_tones_reg == '0);
        for (int k = 0; k < MAX_TONES; k++)
        begin
            tone_on[k] = int'(active_tones_reg) > k;
            if (tone_on[k] && tone_word_reg[k][INC_W-1])
            begin
                setup_err = 1'b1;
            end
        end
    end

    // per-stage enables: a stage loads when it is empty or its successor moves
    assign en_out   = !out_valid_reg || m_tready;
    assign en3      = !s3_valid_reg || en_out;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage 1: increment times sample index, modulo 2^32
    always_ff @(posedge clk)
    begin
        if (en1 && s_tvalid)
        begin
            for (int k = 0; k < MAX_TONES; k++)
            begin
                phase_mul_reg[k] <= tone_word_reg[k][INC_W-1:0] * s_tdata[TIME_W-1:0];
            end
        end
    end

    // stage 2: add phase offset, look up sine by the top phase bits
    always_ff @(posedge clk)
    begin
        logic [INC_W-1:0] acc;
        if (en2 && s1_valid_reg)
        begin
            for (int k = 0; k < MAX_TONES; k++)
            begin
                acc = phase_mul_reg[k]
                    + {tone_word_reg[k][INC_W+PHASE_W-1:INC_W], {(INC_W-PHASE_W){1'b0}}};
                sine_reg[k] <= $signed(SINE_TABLE[acc[INC_W-1 -: SINE_TABLE_BITS]]);
            end
        end
    end

    // stage 3: amplitude times sine
    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            for (int k = 0; k < MAX_TONES; k++)
            begin
                prod_reg[k] <= $signed({1'b0, tone_word_reg[k][TONE_WORD_W-1 -: AMP_W]})
                             * sine_reg[k];
            end
        end
    end

    // stage 4: floor shift by 15 (arithmetic), sum active tones, saturate; zero on setup error
    always_comb
    begin
        sum = '0;
        for (int k = 0; k < MAX_TONES; k++)
        begin
            if (tone_on[k])
            begin
                sum = sum + SUM_W'($signed(prod_reg[k][PROD_W-1:15]));
            end
        end
        if (setup_err)
        begin
            sample_next = '0;
        end
        else if (sum > SAMPLE_MAX)
        begin
            sample_next = SAMPLE_MAX[SAMPLE_W-1:0];
        end
        else if (sum < SAMPLE_MIN)
        begin
            sample_next = SAMPLE_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            sample_next = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s3_valid_reg)
        begin
            sample_reg <= sample_next;
            err_reg    <= setup_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-SAMPLE_W){1'b0}}, sample_reg};
    assign m_tuser  = err_reg;

endmodule

`default_nettype wire

@@ rtl/mtss_checker.sv @@
// port-level checks for the multi-tone sine generator, bound to the top level
`default_nettype none

module mtss_checker
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [mtss_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input wire logic [0:0]                         m_tuser
);
    import mtss_pkg::*;

    // a stalled sample holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output sample changed while stalled");

    // an error sample carries zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("error sample is not zero");

    // a draining output never blocks new requests
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is taken");

    // padding bits above the sample stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:SAMPLE_W] == '0)
        else $error("padding bits set in output data");

endmodule

bind multi_tone_sine_sum mtss_checker u_mtss_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
